/* rtl/edfs_pkg.sv */
package edfs_pkg;

  localparam int SLOT_PORT_W = 7;
  localparam int DAY_PORT_W  = 10;
  localparam int WORK_W      = 10;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_REST = 2'd0,
    KIND_WORK = 2'd1,
    KIND_EXAM = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    op_t                    operation;
    logic [SLOT_PORT_W-1:0] slot;
    logic [DAY_PORT_W-1:0]  release_day;
    logic [DAY_PORT_W-1:0]  deadline_day;
    logic [WORK_W-1:0]      work_days;
    logic [DAY_PORT_W-1:0]  day;
  } in_word_t;

  typedef struct packed {
    kind_t                  kind;
    logic [SLOT_PORT_W-1:0] task_res;
    logic                   all_done;
  } out_word_t;

  // control from the sequencer into the selection unit
  typedef struct packed {
    logic start;
    logic rvalid;
  } sel_ctl_t;

  // scan summary back to the sequencer
  typedef struct packed {
    logic exam;
    logic found;
    logic all_done;
  } sel_stat_t;

endpackage

/* rtl/edfs_ram.sv */
module edfs_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/edfs_sel.sv */
module edfs_sel #(
  parameter int MAX_TASKS = 128,
  parameter int DAY_BITS  = 10
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  edfs_pkg::sel_ctl_t                         ctl,
  input  logic [$clog2(MAX_TASKS)-1:0]               ridx,
  input  logic [DAY_BITS-1:0]                        day,
  input  logic [2*DAY_BITS+edfs_pkg::WORK_W:0]       rdata,
  output edfs_pkg::sel_stat_t                        stat,
  output logic [$clog2(MAX_TASKS)-1:0]               best_idx,
  output logic [DAY_BITS-1:0]                        best_rel,
  output logic [DAY_BITS-1:0]                        best_dl,
  output logic [edfs_pkg::WORK_W-1:0]                best_rem
);

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int WW     = edfs_pkg::WORK_W;

  logic              e_valid;
  logic [DAY_BITS-1:0] e_rel;
  logic [DAY_BITS-1:0] e_dl;
  logic [WW-1:0]     e_rem;

  logic exam_hit, pend, elig, better;

  logic              exam_r, exam_nxt;
  logic              found_r, found_nxt;
  logic [1:0]        pcnt_r, pcnt_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [DAY_BITS-1:0] rel_r, rel_nxt;
  logic [DAY_BITS-1:0] dl_r, dl_nxt;
  logic [WW-1:0]     rem_r, rem_nxt;

  assign {e_valid, e_rel, e_dl, e_rem} = rdata;

  always_comb begin
    exam_hit = e_valid && (e_dl == day);
    pend     = e_valid && (e_rem != '0);
    elig     = pend && (e_rel <= day) && (day < e_dl);
    // strict compares keep the lower slot on a full tie
    better   = !found_r || (e_dl < dl_r) || ((e_dl == dl_r) && (e_rel < rel_r));
  end

  always_comb begin
    exam_nxt  = exam_r;
    found_nxt = found_r;
    pcnt_nxt  = pcnt_r;
    idx_nxt   = idx_r;
    rel_nxt   = rel_r;
    dl_nxt    = dl_r;
    rem_nxt   = rem_r;
    if (ctl.start) begin
      exam_nxt  = 1'b0;
      found_nxt = 1'b0;
      pcnt_nxt  = 2'd0;
    end else if (ctl.rvalid) begin
      if (exam_hit) begin
        exam_nxt = 1'b1;
      end
      if (pend && (pcnt_r != 2'd2)) begin
        pcnt_nxt = pcnt_r + 2'd1;
      end
      if (elig && better) begin
        found_nxt = 1'b1;
        idx_nxt   = ridx;
        rel_nxt   = e_rel;
        dl_nxt    = e_dl;
        rem_nxt   = e_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exam_r  <= 1'b0;
      found_r <= 1'b0;
      pcnt_r  <= 2'd0;
    end else begin
      exam_r  <= exam_nxt;
      found_r <= found_nxt;
      pcnt_r  <= pcnt_nxt;
    end
    idx_r <= idx_nxt;
    rel_r <= rel_nxt;
    dl_r  <= dl_nxt;
    rem_r <= rem_nxt;
  end

  always_comb begin
    stat.exam  = exam_r;
    stat.found = found_r;
    // the chosen slot finishes when it was the only one pending with one day left
    if (exam_r) begin
      stat.all_done = (pcnt_r == 2'd0);
    end else begin
      stat.all_done = (pcnt_r == 2'd0) ||
                      ((pcnt_r == 2'd1) && found_r && (rem_r == WW'(1)));
    end
  end

  assign best_idx = idx_r;
  assign best_rel = rel_r;
  assign best_dl  = dl_r;
  assign best_rem = rem_r;

endmodule

/* rtl/edf_task_day_scheduler.sv */
// earliest deadline first day scheduler
// input channel (in_valid/in_ready/in_data): a load word writes one task slot
// (release day, deadline day, work days) and gives no result; a tick word
// carries a day and gives exactly one result word
// result channel (out_valid/out_ready/out_data): kind is rest, work or exam,
// task_res names the slot worked on, all_done is set when no loaded task has
// work left after that day
// a load leaves the sequencer idle and ready for the next word; after a tick
// in_ready stays low while the scan reads every slot from the task memory
// (one write port, one read port), one slot a cycle, and until the result
// is written into the output register in the result state after the scan
// after reset a clearing pass writes every slot of the task memory empty;
// in_ready stays low until it is done
// if the receiver stalls, the finished tick waits before write-back until
// the output register is free; a following load is taken meanwhile only
// once that tick has been delivered into the output register
module edf_task_day_scheduler #(
  parameter int MAX_TASKS = 128,
  parameter int DAY_BITS  = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  edfs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output edfs_pkg::out_word_t out_data
);

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int WW     = edfs_pkg::WORK_W;
  localparam int ENT_W  = 1 + 2 * DAY_BITS + WW;

  edfs_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DAY_BITS-1:0] day_r, day_nxt;
  logic                rv_r, rv_nxt;
  logic [SLOT_W-1:0]   ridx_r, ridx_nxt;
  logic                out_valid_r, out_valid_nxt;
  edfs_pkg::out_word_t out_r, out_nxt;

  logic              in_fire, out_free, issue, clear_last;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;

  edfs_pkg::sel_ctl_t  sel_ctl;
  edfs_pkg::sel_stat_t sel_stat;
  logic [SLOT_W-1:0]   best_idx;
  logic [DAY_BITS-1:0] best_rel, best_dl;
  logic [WW-1:0]       best_rem;

  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign issue      = (cnt_r < CNT_W'(MAX_TASKS));
  assign clear_last = (cnt_r == CNT_W'(MAX_TASKS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      edfs_pkg::ST_CLEAR: begin
        if (clear_last) begin
          state_nxt = edfs_pkg::ST_IDLE;
        end
      end
      edfs_pkg::ST_IDLE: begin
        if (in_fire && (in_data.operation == edfs_pkg::OP_TICK)) begin
          state_nxt = edfs_pkg::ST_SCAN;
        end
      end
      edfs_pkg::ST_SCAN: begin
        if (!issue) begin
          state_nxt = edfs_pkg::ST_RESULT;
        end
      end
      edfs_pkg::ST_RESULT: begin
        if (out_free) begin
          state_nxt = edfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = edfs_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[SLOT_W-1:0];
    ram_wdata      = '0;
    ram_raddr      = cnt_r[SLOT_W-1:0];
    sel_ctl.start  = 1'b0;
    sel_ctl.rvalid = rv_r;
    case (state_r)
      edfs_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      edfs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && (in_data.operation == edfs_pkg::OP_LOAD) &&
            (int'(in_data.slot) < MAX_TASKS)) begin
          ram_we    = 1'b1;
          ram_waddr = SLOT_W'(in_data.slot);
          ram_wdata = {1'b1, DAY_BITS'(in_data.release_day),
                       DAY_BITS'(in_data.deadline_day), in_data.work_days};
        end
        if (in_fire && (in_data.operation == edfs_pkg::OP_TICK)) begin
          sel_ctl.start = 1'b1;
        end
      end
      edfs_pkg::ST_SCAN: begin
      end
      edfs_pkg::ST_RESULT: begin
        if (out_free && sel_stat.found && !sel_stat.exam) begin
          ram_we    = 1'b1;
          ram_waddr = best_idx;
          ram_wdata = {1'b1, best_rel, best_dl, best_rem - WW'(1)};
        end
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_comb begin
    cnt_nxt       = cnt_r;
    day_nxt       = day_r;
    rv_nxt        = 1'b0;
    ridx_nxt      = ridx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      edfs_pkg::ST_CLEAR: begin
        cnt_nxt = clear_last ? '0 : cnt_r + CNT_W'(1);
      end
      edfs_pkg::ST_IDLE: begin
        if (in_fire && (in_data.operation == edfs_pkg::OP_TICK)) begin
          cnt_nxt = '0;
          day_nxt = DAY_BITS'(in_data.day);
        end
      end
      edfs_pkg::ST_SCAN: begin
        if (issue) begin
          rv_nxt   = 1'b1;
          ridx_nxt = cnt_r[SLOT_W-1:0];
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      edfs_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_nxt.all_done  = sel_stat.all_done;
          if (sel_stat.exam) begin
            out_nxt.kind     = edfs_pkg::KIND_EXAM;
            out_nxt.task_res = '0;
          end else if (sel_stat.found) begin
            out_nxt.kind     = edfs_pkg::KIND_WORK;
            out_nxt.task_res = edfs_pkg::SLOT_PORT_W'(best_idx);
          end else begin
            out_nxt.kind     = edfs_pkg::KIND_REST;
            out_nxt.task_res = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edfs_pkg::ST_CLEAR;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    day_r  <= day_nxt;
    ridx_r <= ridx_nxt;
    out_r  <= out_nxt;
  end

  edfs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  edfs_sel #(
    .MAX_TASKS (MAX_TASKS),
    .DAY_BITS  (DAY_BITS)
  ) u_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sel_ctl),
    .ridx     (ridx_r),
    .day      (day_r),
    .rdata    (ram_rdata),
    .stat     (sel_stat),
    .best_idx (best_idx),
    .best_rel (best_rel),
    .best_dl  (best_dl),
    .best_rem (best_rem)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_TASKS = 128;
  localparam int PARK_DAY  = 1023;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  edfs_pkg::in_word_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  edfs_pkg::out_word_t out_data;

  // own copy of the task table
  bit         task_loaded   [MAX_TASKS];
  logic [9:0] task_release  [MAX_TASKS];
  logic [9:0] task_deadline [MAX_TASKS];
  logic [9:0] task_left     [MAX_TASKS];
  bit         touched       [MAX_TASKS];

  edfs_pkg::out_word_t pending_days[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int words_sent     = 0;
  int loads_sent     = 0;
  int ticks_sent     = 0;
  int rest_seen      = 0;
  int work_seen      = 0;
  int exam_seen      = 0;

  edf_task_day_scheduler #(
    .MAX_TASKS (MAX_TASKS),
    .DAY_BITS  (10)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // updates the task table; returns 1 with the day result for a tick
  function automatic bit plan_day(input edfs_pkg::in_word_t w,
                                  output edfs_pkg::out_word_t r);
    bit exam;
    bit found;
    int pick;
    int i;
    exam  = 1'b0;
    found = 1'b0;
    pick  = 0;
    r     = '0;
    if (w.operation == edfs_pkg::OP_LOAD) begin
      task_loaded[w.slot]   = 1'b1;
      task_release[w.slot]  = w.release_day;
      task_deadline[w.slot] = w.deadline_day;
      task_left[w.slot]     = w.work_days;
      return 1'b0;
    end
    for (i = 0; i < MAX_TASKS; i++) begin
      if (task_loaded[i] && task_deadline[i] == w.day) exam = 1'b1;
    end
    if (exam) begin
      r.kind = edfs_pkg::KIND_EXAM;
    end else begin
      for (i = 0; i < MAX_TASKS; i++) begin
        if (!task_loaded[i] || task_left[i] == 0) continue;
        if (task_release[i] > w.day || w.day >= task_deadline[i]) continue;
        // strict compares keep the lower slot on a full tie
        if (!found || task_deadline[i] < task_deadline[pick] ||
            (task_deadline[i] == task_deadline[pick] &&
             task_release[i] < task_release[pick])) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        r.kind          = edfs_pkg::KIND_WORK;
        r.task_res      = 7'(pick);
        task_left[pick] = task_left[pick] - 10'd1;
      end else begin
        r.kind = edfs_pkg::KIND_REST;
      end
    end
    r.all_done = 1'b1;
    for (i = 0; i < MAX_TASKS; i++) begin
      if (task_loaded[i] && task_left[i] != 0) r.all_done = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_word(input edfs_pkg::in_word_t w);
    edfs_pkg::out_word_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (plan_day(w, r)) begin
      pending_days = {pending_days, r};
      ticks_sent++;
    end else begin
      loads_sent++;
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic load_slot(input int s, input int rel, input int dl, input int wd);
    edfs_pkg::in_word_t w;
    w.operation    = edfs_pkg::OP_LOAD;
    w.slot         = 7'(s);
    w.release_day  = 10'(rel);
    w.deadline_day = 10'(dl);
    w.work_days    = 10'(wd);
    w.day          = 10'($urandom_range(1023));
    touched[s]     = 1'b1;
    send_word(w);
  endtask

  task automatic tick_day(input int d);
    edfs_pkg::in_word_t w;
    w.operation    = edfs_pkg::OP_TICK;
    w.slot         = 7'($urandom_range(127));
    w.release_day  = 10'($urandom_range(1023));
    w.deadline_day = 10'($urandom_range(1023));
    w.work_days    = 10'($urandom_range(1023));
    w.day          = 10'(d);
    send_word(w);
  endtask

  // retire used slots: no work left and the exam pushed out to the last day
  task automatic park_touched();
    edfs_pkg::in_word_t w;
    int i;
    for (i = 0; i < MAX_TASKS; i++) begin
      if (touched[i]) begin
        w.operation    = edfs_pkg::OP_LOAD;
        w.slot         = 7'(i);
        w.release_day  = 10'd1;
        w.deadline_day = 10'(PARK_DAY);
        w.work_days    = 10'd0;
        w.day          = 10'($urandom_range(1023));
        touched[i]     = 1'b0;
        send_word(w);
      end
    end
  endtask

  task automatic test_corner_words();
    tick_day(5);
    // never released before its own exam, keeps all_done low
    load_slot(127, 1023, 1023, 1023);
    // no work but still an exam day
    load_slot(0, 1, 3, 0);
    load_slot(1, 1, 10, 2);
    load_slot(2, 1, 10, 1);
    load_slot(3, 2, 8, 1);
    tick_day(1);
    tick_day(2);
    tick_day(3);
    tick_day(4);
    tick_day(5);
    tick_day(6);
    // equal deadlines, the earlier release goes first
    load_slot(1, 5, 12, 1);
    load_slot(2, 4, 12, 1);
    tick_day(7);
    tick_day(6);
    tick_day(1023);
    load_slot(85, 0, 1, 1);
    tick_day(0);
    load_slot(127, 1023, 1023, 0);
    tick_day(9);
    park_touched();
  endtask

  // well-formed plans: a handful of tasks in a window, its days mostly in order
  task automatic test_edf_plans(input int budget);
    int stop;
    int k;
    int base;
    int span;
    int rel;
    int dl;
    int wd;
    int d;
    int j;
    bit heavy;
    stop = words_sent + budget;
    rel  = 1;
    dl   = 2;
    while (words_sent < stop) begin
      k     = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
      span  = $urandom_range(4, 40);
      base  = $urandom_range(1, 1021 - span);
      heavy = ($urandom_range(4) == 0);
      for (j = 0; j < k; j++) begin
        if (j == 0 || $urandom_range(3) != 0) begin
          rel = base + $urandom_range(0, span / 2);
          dl  = rel + $urandom_range(1, base + span - rel);
        end else if ($urandom_range(1) == 1) begin
          // same deadline as the last task, release drawn anew
          rel = base + $urandom_range(0, dl - base - 1);
        end
        if (heavy) begin
          wd = $urandom_range(0, dl - rel + 2);
          if ($urandom_range(7) == 0) wd = $urandom_range(1023);
        end else begin
          wd = $urandom_range(0, (dl - rel + k - 1) / k);
        end
        load_slot($urandom_range(127), rel, dl, wd);
      end
      d = base;
      while (d <= base + span + 1) begin
        if ($urandom_range(19) == 0) tick_day($urandom_range(base, base + span));
        tick_day(d);
        d += ($urandom_range(9) == 0) ? 2 : 1;
      end
      park_touched();
    end
  endtask

  task automatic test_stray_words(input int n);
    int j;
    for (j = 0; j < n; j++) begin
      if ($urandom_range(1) == 1) begin
        load_slot($urandom_range(127), $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023));
      end else begin
        tick_day($urandom_range(1023));
      end
    end
    park_touched();
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_day_result
    edfs_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_days.size() == 0) begin
        $display("%0t: unexpected result word kind=%0d task=%0d all_done=%0d",
                 $time, out_data.kind, out_data.task_res, out_data.all_done);
        error_count++;
      end else begin
        want = pending_days.pop_front();
        case (want.kind)
          edfs_pkg::KIND_REST: rest_seen++;
          edfs_pkg::KIND_WORK: work_seen++;
          default:             exam_seen++;
        endcase
        if (out_data.kind !== want.kind || out_data.task_res !== want.task_res ||
            out_data.all_done !== want.all_done) begin
          $display("%0t: expected kind=%0d task=%0d all_done=%0d, %s%0d task=%0d all_done=%0d",
                   $time, want.kind, want.task_res, want.all_done, "got kind=",
                   out_data.kind, out_data.task_res, out_data.all_done);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct  = 30;
    recv_stall_pct = 53;
    test_corner_words();
    test_edf_plans(500);
    test_stray_words(40);
    send_idle_pct  = 53;
    recv_stall_pct = 30;
    test_edf_plans(500);
    test_stray_words(40);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_edf_plans(500);
    test_stray_words(40);
    in_valid <= 1'b0;
    wait (pending_days.size() == 0);
    // a stray result would show up within a scan or two
    repeat (4 * MAX_TASKS) @(posedge clk);
    $display("%0d words sent: %0d loads, %0d day ticks", words_sent, loads_sent, ticks_sent);
    $display("day results checked: %0d rest, %0d work, %0d exam", rest_seen, work_seen,
             exam_seen);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // several times the slowest expected run
  initial begin
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/edfs_pkg.sv
rtl/edfs_ram.sv
rtl/edfs_sel.sv
rtl/edf_task_day_scheduler.sv
dv/testbench.sv
